// File: src/assert_macros.svh
// Assertion macros used by the top-level RTL file of the table engine.
// Depends on nothing; simulation builds see the checks, synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that cons holds in the same cycle whenever ante holds.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that cons holds in the cycle after ante holds.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: src/ate_pkg.sv
// Package of the table engine: sizes, operation and status codes, shared types.
// Depends on nothing; used by every module of the engine.
package ate_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int OP_W   = 3;
  localparam int SLOT_W = 7;
  localparam int STAT_W = 3;

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_DUMP   = 3'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd4;
  localparam logic [OP_W-1:0] OP_SORT   = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_POS   = 3'd4;

  // Flags of the shared compare unit.
  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_flags_t;

endpackage

// File: src/ate_ram.sv
// Word store of the table engine: one write port, one read port with registered data.
// Depends on ate_pkg.
module ate_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ate_pkg::ADDR_W-1:0]  waddr,
  input  logic [ate_pkg::WORD_W-1:0]  wdata,
  input  logic [ate_pkg::ADDR_W-1:0]  raddr,
  output logic [ate_pkg::WORD_W-1:0]  rdata
);
  import ate_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/ate_cmp.sv
// Shared compare unit: equality for search, signed greater-than for sort.
// Depends on ate_pkg.
module ate_cmp (
  input  logic [ate_pkg::WORD_W-1:0] lhs,
  input  logic [ate_pkg::WORD_W-1:0] rhs,
  output ate_pkg::cmp_flags_t        flags
);
  import ate_pkg::*;

  always_comb begin
    flags.eq = (lhs == rhs);
    flags.gt = ($signed(lhs) > $signed(rhs));
  end

endmodule

// File: src/array_table_engine.sv
// Top level of the table engine: request decode, sequencer and result register.
// Depends on ate_pkg, ate_ram, ate_cmp and assert_macros.svh.

// The engine keeps a packed table of up to 64 signed 32-bit words and runs
// one request at a time. A request is taken at a clock edge with start high
// and busy low. Every result appears for exactly one cycle with strobe high
// and cannot be held off, so capture it when strobe is seen; last_of_run
// marks the final result of a request. Append, update, a rejected request,
// a dump or search of an empty table, a sort of fewer than two words and a
// delete of the last word finish without raising busy: the result shows in
// the cycle after the request is taken, and a new request may be taken in
// that same cycle. The rest walk the table through one memory read port
// with registered read data, one word at a time through S_RD and S_USE:
// dump gives one result per word read, search stops at the first hit,
// delete shifts each later word down one place, and sort makes one pass
// for each slot but the last, using the single read port and one compare
// unit and writing the pass minimum back in S_PUT.
// Codes six and seven are taken and dropped with no result.
`include "assert_macros.svh"

module array_table_engine (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [ate_pkg::OP_W-1:0]           operation,
  input  logic signed [ate_pkg::WORD_W-1:0]  operand_value,
  input  logic [ate_pkg::SLOT_W-1:0]         slot_number,
  output logic                               strobe,
  output logic [ate_pkg::STAT_W-1:0]         status,
  output logic signed [ate_pkg::WORD_W-1:0]  element_out,
  output logic [ate_pkg::SLOT_W-1:0]         found_at,
  output logic                               last_of_run
);
  import ate_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;  // address out, data comes next cycle
  localparam logic [1:0] S_USE  = 2'd2;  // read data valid, act on it
  localparam logic [1:0] S_PUT  = 2'd3;  // sort: write back the pass minimum

  localparam int EXT_W = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;

  // Sequencer registers
  logic [1:0]        state, state_next;
  logic [OP_W-1:0]   op_r, op_next;
  logic [WORD_W-1:0] key, key_next;
  logic [ADDR_W-1:0] addr, addr_next;
  logic [ADDR_W-1:0] base, base_next;     // sort: slot being settled
  logic              pmode, pmode_next;   // sort: high once the pivot is loaded
  logic [WORD_W-1:0] pivot, pivot_next;
  logic [CNT_W-1:0]  cnt, cnt_next;

  // Memory port
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] rdata;

  // Result to register
  logic              emit;
  logic [STAT_W-1:0] em_status;
  logic [WORD_W-1:0] em_elem;
  logic [SLOT_W-1:0] em_pos;
  logic              em_last;

  logic [WORD_W-1:0] cmp_lhs;
  cmp_flags_t        flags;

  logic [EXT_W-1:0]  slot_ext;
  logic [EXT_W-1:0]  cnt_ext;
  logic              slot_ok;
  logic [ADDR_W-1:0] slot_idx;
  logic              at_end;

  ate_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  // Search compares against the key, sort against the running pivot.
  assign cmp_lhs = (op_r == OP_SEARCH) ? key : pivot;

  ate_cmp u_cmp (
    .lhs   (cmp_lhs),
    .rhs   (rdata),
    .flags (flags)
  );

  assign busy     = (state != S_IDLE);
  assign slot_ext = EXT_W'(slot_number);
  assign cnt_ext  = EXT_W'(cnt);
  assign slot_ok  = (slot_number != '0) && (slot_ext <= cnt_ext);
  assign slot_idx = ADDR_W'(slot_number - SLOT_W'(1));
  assign at_end   = (CNT_W'(addr) == (cnt - CNT_W'(1)));

  always_comb begin
    state_next = state;
    op_next    = op_r;
    key_next   = key;
    addr_next  = addr;
    base_next  = base;
    pmode_next = pmode;
    pivot_next = pivot;
    cnt_next   = cnt;
    we         = 1'b0;
    waddr      = addr;
    wdata      = rdata;
    emit       = 1'b0;
    em_status  = ST_OK;
    em_elem    = '0;
    em_pos     = '0;
    em_last    = 1'b1;

    case (state)
      S_IDLE: begin
        if (start) begin
          op_next  = operation;
          key_next = operand_value;
          case (operation)
            OP_APPEND: begin
              emit = 1'b1;
              if (cnt >= CNT_W'(DEPTH)) begin
                em_status = ST_FULL;
              end else begin
                we       = 1'b1;
                waddr    = ADDR_W'(cnt);
                wdata    = operand_value;
                cnt_next = cnt + CNT_W'(1);
              end
            end
            OP_DUMP: begin
              if (cnt == '0) begin
                emit      = 1'b1;
                em_status = ST_EMPTY;
              end else begin
                addr_next  = '0;
                state_next = S_RD;
              end
            end
            OP_SEARCH: begin
              if (cnt == '0) begin
                emit      = 1'b1;
                em_status = ST_NOT_FOUND;
              end else begin
                addr_next  = '0;
                state_next = S_RD;
              end
            end
            OP_UPDATE: begin
              emit = 1'b1;
              if (!slot_ok) begin
                em_status = ST_BAD_POS;
              end else begin
                we    = 1'b1;
                waddr = slot_idx;
                wdata = operand_value;
              end
            end
            OP_DELETE: begin
              if (!slot_ok) begin
                emit      = 1'b1;
                em_status = ST_BAD_POS;
              end else if (slot_ext == cnt_ext) begin
                // last word: nothing to shift
                emit     = 1'b1;
                cnt_next = cnt - CNT_W'(1);
              end else begin
                // read the word after the hole first
                addr_next  = ADDR_W'(slot_number);
                state_next = S_RD;
              end
            end
            OP_SORT: begin
              if (cnt < CNT_W'(2)) begin
                emit = 1'b1;
              end else begin
                base_next  = '0;
                addr_next  = '0;
                pmode_next = 1'b0;
                state_next = S_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_RD: begin
        state_next = S_USE;
      end

      S_USE: begin
        case (op_r)
          OP_DUMP: begin
            emit    = 1'b1;
            em_elem = rdata;
            em_last = at_end;
            if (at_end) begin
              state_next = S_IDLE;
            end else begin
              addr_next  = addr + ADDR_W'(1);
              state_next = S_RD;
            end
          end
          OP_SEARCH: begin
            if (flags.eq) begin
              emit       = 1'b1;
              em_pos     = SLOT_W'(addr) + SLOT_W'(1);
              state_next = S_IDLE;
            end else if (at_end) begin
              emit       = 1'b1;
              em_status  = ST_NOT_FOUND;
              state_next = S_IDLE;
            end else begin
              addr_next  = addr + ADDR_W'(1);
              state_next = S_RD;
            end
          end
          OP_DELETE: begin
            we    = 1'b1;
            waddr = addr - ADDR_W'(1);
            wdata = rdata;
            if (at_end) begin
              emit       = 1'b1;
              cnt_next   = cnt - CNT_W'(1);
              state_next = S_IDLE;
            end else begin
              addr_next  = addr + ADDR_W'(1);
              state_next = S_RD;
            end
          end
          OP_SORT: begin
            if (!pmode) begin
              pivot_next = rdata;
              pmode_next = 1'b1;
              addr_next  = addr + ADDR_W'(1);
              state_next = S_RD;
            end else begin
              // swap when the pivot is greater: smaller word moves into the pivot
              if (flags.gt) begin
                we         = 1'b1;
                waddr      = addr;
                wdata      = pivot;
                pivot_next = rdata;
              end
              if (at_end) begin
                state_next = S_PUT;
              end else begin
                addr_next  = addr + ADDR_W'(1);
                state_next = S_RD;
              end
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end

      S_PUT: begin
        we    = 1'b1;
        waddr = base;
        wdata = pivot;
        if (CNT_W'(base) == (cnt - CNT_W'(2))) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end else begin
          base_next  = base + ADDR_W'(1);
          addr_next  = base + ADDR_W'(1);
          pmode_next = 1'b0;
          state_next = S_RD;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      strobe <= emit;
    end
  end

  // Working registers and result payload; hold the payload between results
  always_ff @(posedge clk) begin
    op_r  <= op_next;
    key   <= key_next;
    addr  <= addr_next;
    base  <= base_next;
    pmode <= pmode_next;
    pivot <= pivot_next;
    if (emit) begin
      status      <= em_status;
      element_out <= em_elem;
      found_at    <= em_pos;
      last_of_run <= em_last;
    end
  end

  `ASSERT_IMP(a_cnt_bound, clk, rst, 1'b1, cnt <= CNT_W'(DEPTH))
  `ASSERT_IMP(a_last_idle, clk, rst, strobe && last_of_run, !busy)
  `ASSERT_IMP(a_mid_busy, clk, rst, strobe && !last_of_run, busy && (op_r == OP_DUMP))
  `ASSERT_NEXT(a_bad_op_silent, clk, rst, start && !busy && (operation > OP_SORT), !strobe)
  `ASSERT_NEXT(a_cnt_step, clk, rst, 1'b1, (cnt - $past(cnt) + CNT_W'(1)) <= CNT_W'(2))

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for array_table_engine: directed and random requests against
// an in-bench model of the packed word table. Depends on ate_pkg and the engine RTL.

module tb;
  import ate_pkg::*;

  // Codes six and seven are not operations; the engine takes and drops them.
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  localparam int IDLE_PCT      = 36;
  localparam int SETTLE_CYCLES = 300;
  localparam int RANDOM_ITEMS  = 220;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [WORD_W-1:0] element;
    logic [SLOT_W-1:0]        position;
    logic                     last;
  } table_result_t;

  logic                     clk           = 1'b0;
  logic                     rst           = 1'b1;
  logic                     start         = 1'b0;
  logic [OP_W-1:0]          operation     = OP_APPEND;
  logic signed [WORD_W-1:0] operand_value = '0;
  logic [SLOT_W-1:0]        slot_number   = '0;
  logic                     busy;
  logic                     strobe;
  logic [STAT_W-1:0]        status;
  logic signed [WORD_W-1:0] element_out;
  logic [SLOT_W-1:0]        found_at;
  logic                     last_of_run;

  // Shadow copy of the engine's table; only entries below shadow_count are read.
  logic signed [WORD_W-1:0] shadow_words [DEPTH];
  int                       shadow_count;

  // Results owed by the engine, oldest first.
  table_result_t            expected_results [$];

  logic signed [WORD_W-1:0] corner_words [5] = '{WORD_MIN, WORD_MAX, 32'sd0, -32'sd1, 32'sd1};

  bit gaps_on = 1'b1;
  int requests_sent;
  int results_checked;
  int failures;
  int full_hits;
  int op_tally [8];

  array_table_engine u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .operand_value(operand_value),
    .slot_number  (slot_number),
    .strobe       (strobe),
    .status       (status),
    .element_out  (element_out),
    .found_at     (found_at),
    .last_of_run  (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Table model: apply one accepted request and queue the results it owes.
  // ---------------------------------------------------------------------------
  function automatic void predict_request(input logic [OP_W-1:0] op,
                                          input logic signed [WORD_W-1:0] value,
                                          input logic [SLOT_W-1:0] slot);
    table_result_t            r;
    logic signed [WORD_W-1:0] held;
    int                       hit;
    r = '{status: ST_OK, element: '0, position: '0, last: 1'b1};
    case (op)
      OP_APPEND: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
          full_hits++;
        end else begin
          shadow_words[shadow_count] = value;
          shadow_count++;
        end
        expected_results.push_back(r);
      end
      OP_DUMP: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
          expected_results.push_back(r);
        end else begin
          // One result per word, in table order; flag the last one.
          for (int i = 0; i < shadow_count; i++) begin
            r.element = shadow_words[i];
            r.last    = (i == shadow_count - 1);
            expected_results.push_back(r);
          end
        end
      end
      OP_SEARCH: begin
        hit = 0;
        for (int i = 0; i < shadow_count; i++)
          if (hit == 0 && shadow_words[i] == value) hit = i + 1;
        if (hit == 0) r.status = ST_NOT_FOUND;
        else r.position = SLOT_W'(hit);
        expected_results.push_back(r);
      end
      OP_UPDATE: begin
        if (slot < 1 || slot > shadow_count) r.status = ST_BAD_POS;
        else shadow_words[slot - 1] = value;
        expected_results.push_back(r);
      end
      OP_DELETE: begin
        if (slot < 1 || slot > shadow_count) begin
          r.status = ST_BAD_POS;
        end else begin
          // Close the gap: every later word moves down one place.
          for (int i = slot - 1; i + 1 < shadow_count; i++)
            shadow_words[i] = shadow_words[i + 1];
          shadow_count--;
        end
        expected_results.push_back(r);
      end
      OP_SORT: begin
        // Exchange sort, ascending, signed compare.
        for (int i = 0; i < shadow_count; i++)
          for (int j = i + 1; j < shadow_count; j++)
            if (shadow_words[i] > shadow_words[j]) begin
              held            = shadow_words[i];
              shadow_words[i] = shadow_words[j];
              shadow_words[j] = held;
            end
        expected_results.push_back(r);
      end
      default: ;  // spare codes: no result, no change
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver. Start stays high from one request to the next unless a gap
  // falls between them, so start never gets two assignments in one step.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [OP_W-1:0] op,
                              input logic signed [WORD_W-1:0] value,
                              input logic [SLOT_W-1:0] slot);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    operation     <= op;
    operand_value <= value;
    slot_number   <= slot;
    @(posedge clk);
    // Hold the request until an edge sees busy low.
    while (busy) @(posedge clk);
    requests_sent++;
    op_tally[op]++;
    predict_request(op, value, slot);
  endtask

  // Drop start and hold off until every owed result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: each strobe pops and compares the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    table_result_t want;
    if (!rst && strobe !== 1'b0) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d element %0d found_at %0d last %0b",
               status, element_out, found_at, last_of_run);
        failures++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (strobe !== 1'b1) begin
          $error("strobe: expected 1, got %b", strobe);
          failures++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          failures++;
        end
        if (element_out !== want.element) begin
          $error("element_out: expected %0d, got %0d", want.element, element_out);
          failures++;
        end
        if (found_at !== want.position) begin
          $error("found_at: expected %0d, got %0d", want.position, found_at);
          failures++;
        end
        if (last_of_run !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
          failures++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Operand pickers: corner words, a narrow band that breeds duplicates, and
  // full-range words.
  // ---------------------------------------------------------------------------
  function automatic logic signed [WORD_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return corner_words[$urandom_range(0, 4)];
    if (r < 50) return WORD_W'(int'($urandom_range(0, 15)) - 8);
    return $urandom;
  endfunction

  // Mostly hit a word that is in the table; otherwise probe for a miss.
  function automatic logic signed [WORD_W-1:0] pick_search_word();
    if (shadow_count > 0 && $urandom_range(0, 99) < 60)
      return shadow_words[$urandom_range(0, shadow_count - 1)];
    return pick_word();
  endfunction

  // Mostly valid positions, some just outside the table, some anywhere.
  function automatic logic [SLOT_W-1:0] pick_slot();
    int r;
    r = $urandom_range(0, 99);
    if (shadow_count > 0 && r < 80) return SLOT_W'($urandom_range(1, shadow_count));
    if (r < 90) return r[0] ? SLOT_W'(shadow_count + 1) : '0;
    return SLOT_W'($urandom_range(0, 127));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every operation but append on an empty table, plus both spare codes.
  task automatic test_empty_table();
    send_request(OP_DUMP,     '0,       '0);
    send_request(OP_SORT,     '0,       '0);
    send_request(OP_SEARCH,   '0,       '0);
    send_request(OP_UPDATE,   32'sd5,   7'd1);
    send_request(OP_DELETE,   '0,       7'd1);
    send_request(OP_SPARE_LO, WORD_MAX, 7'd127);
    send_request(OP_SPARE_HI, WORD_MIN, '0);
  endtask

  // Corner words, hits and misses, bad positions at both ends, first-equal search.
  task automatic test_corner_words();
    foreach (corner_words[i]) send_request(OP_APPEND, corner_words[i], '0);
    send_request(OP_SEARCH, WORD_MAX, '0);
    send_request(OP_SEARCH, 32'sd2,   '0);
    send_request(OP_APPEND, -32'sd1,  '0);
    send_request(OP_SEARCH, -32'sd1,  '0);
    send_request(OP_UPDATE, 32'sd9,   '0);
    send_request(OP_UPDATE, 32'sd9,   7'd127);
    send_request(OP_UPDATE, 32'sd9,   SLOT_W'(shadow_count + 1));
    send_request(OP_UPDATE, WORD_MIN, 7'd3);
    send_request(OP_DELETE, '0,       7'd1);
    send_request(OP_DELETE, '0,       SLOT_W'(shadow_count));
    send_request(OP_SORT,   '0,       '0);
    send_request(OP_DUMP,   '0,       '0);
  endtask

  // Fill to capacity, hit the full case, walk the whole table, then shrink back.
  task automatic test_full_table();
    drain_results();
    while (shadow_count < DEPTH) send_request(OP_APPEND, pick_word(), '0);
    send_request(OP_APPEND, WORD_MAX, '0);
    send_request(OP_APPEND, WORD_MIN, '0);
    send_request(OP_SEARCH, shadow_words[DEPTH - 1], '0);
    send_request(OP_DUMP,   '0, '0);
    send_request(OP_SORT,   '0, '0);
    send_request(OP_DUMP,   '0, '0);
    send_request(OP_UPDATE, 32'sd77, SLOT_W'(DEPTH));
    send_request(OP_UPDATE, 32'sd77, SLOT_W'(DEPTH + 1));
    send_request(OP_DELETE, '0, SLOT_W'(DEPTH));
    send_request(OP_DELETE, '0, 7'd1);
    while (shadow_count > 8)
      send_request(OP_DELETE, '0, SLOT_W'($urandom_range(1, shadow_count)));
  endtask

  // Weighted random mix; append weight follows the fill level so the table
  // neither starves nor sits at capacity.
  task automatic test_random_mix(input int items);
    logic [OP_W-1:0] op;
    int              append_pct;
    int              r;
    for (int k = 0; k < items; k++) begin
      gaps_on = !(k >= 70 && k < 130);  // back-to-back stretch
      if (k == 150) drain_results();
      append_pct = (shadow_count < 12) ? 40 : (shadow_count > 40) ? 10 : 22;
      if ($urandom_range(0, 99) < append_pct) begin
        op = OP_APPEND;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8)       op = OP_DUMP;
        else if (r < 40) op = OP_SEARCH;
        else if (r < 62) op = OP_UPDATE;
        else if (r < 90) op = OP_DELETE;
        else if (r < 95) op = OP_SORT;
        else             op = r[0] ? OP_SPARE_LO : OP_SPARE_HI;
      end
      case (op)
        OP_SEARCH:            send_request(op, pick_search_word(), SLOT_W'($urandom));
        OP_UPDATE, OP_DELETE: send_request(op, pick_word(), pick_slot());
        default:              send_request(op, pick_word(), SLOT_W'($urandom));
      endcase
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_corner_words();
    test_full_table();
    test_random_mix(RANDOM_ITEMS);

    // Let owed results land, then give dropped codes time to settle.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d requests: append %0d, dump %0d, search %0d, update %0d, delete %0d,",
             requests_sent, op_tally[OP_APPEND], op_tally[OP_DUMP], op_tally[OP_SEARCH],
             op_tally[OP_UPDATE], op_tally[OP_DELETE]);
    $display("sort %0d, spare codes %0d; %0d results checked, full table hit %0d times.",
             op_tally[OP_SORT], op_tally[OP_SPARE_LO] + op_tally[OP_SPARE_HI],
             results_checked, full_hits);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond even a run of nothing but full-table sorts.
  initial begin
    #60_000_000;
    $display("timeout with %0d results still owed", expected_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
